/* sv/pf_pkg.sv */
`default_nettype none

package pf_pkg;

  localparam logic [4:0] LETTER_I     = 5'd8;
  localparam logic [4:0] LETTER_J     = 5'd9;
  localparam logic [4:0] LETTER_Z     = 5'd25;
  localparam logic [4:0] FILLER_RESET = 5'd23;
  localparam logic [4:0] SQUARE_CELLS = 5'd25;
  localparam int         ALPHABET     = 26;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_KEY    = 3'd1,
    OP_FINISH = 3'd2,
    OP_ENC    = 3'd3,
    OP_DEC    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PLACE,
    CMD_FINISH,
    CMD_PAIR
  } cmd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_EMIT0,
    ST_EMIT1
  } back_st_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [4:0] a;
    logic [4:0] b;
    logic       dec;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [4:0] letter;
    logic       last;
  } res_t;

  // clamp to Z, fold J into I
  function automatic logic [4:0] norm_letter(input logic [4:0] v);
    logic [4:0] x;
    x = (v > LETTER_Z) ? LETTER_Z : v;
    if (x == LETTER_J) x = LETTER_I;
    return x;
  endfunction

  function automatic cmd_t mk_pair(input logic [4:0] a, input logic [4:0] b,
                                   input logic dec, input logic last);
    cmd_t c;
    c.kind = CMD_PAIR;
    c.a    = a;
    c.b    = b;
    c.dec  = dec;
    c.last = last;
    return c;
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + 5'(r) + 5'(c);
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] diff;
    diff = p - cell_addr(pos_row(p), 3'd0);
    return diff[2:0];
  endfunction

  // +1 or -1 modulo 5
  function automatic logic [2:0] step5(input logic [2:0] v, input logic dec);
    logic [2:0] s;
    if (dec) s = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else     s = (v >= 3'd4) ? 3'd0 : v + 3'd1;
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/pf_front.sv */
`default_nettype none

module pf_front import pf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation_i,
  input  logic [4:0] letter_i,
  input  logic       message_end_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i,
  output logic       cq_push_o,
  output cmd_t       cq_cmd_o,
  input  logic       cq_full_i
);

  logic [4:0] filler_q;
  logic       pend_v_q, pend_v_d;
  logic [4:0] pend_l_q, pend_l_d;
  logic       spare_v_q, spare_v_d;
  cmd_t       spare_q, spare_d;

  logic       accept;
  logic [4:0] x, fill;
  logic       dec;
  logic       first_v, second_v;
  cmd_t       first, second;

  assign cfg_ready_o = 1'b1;
  assign full        = spare_v_q | cq_full_i;
  assign accept      = push & ~full;

  always_comb begin
    x        = norm_letter(letter_i);
    fill     = norm_letter(filler_q);
    dec      = (operation_i == OP_DEC);
    first_v  = 1'b0;
    second_v = 1'b0;
    first    = mk_pair(x, fill, dec, 1'b0);
    second   = mk_pair(x, fill, dec, 1'b1);
    pend_v_d = pend_v_q;
    pend_l_d = pend_l_q;
    case (op_e'(operation_i))
      OP_START: begin
        first_v      = 1'b1;
        first.kind   = CMD_START;
        pend_v_d     = 1'b0;
      end
      OP_KEY: begin
        first_v      = 1'b1;
        first.kind   = CMD_PLACE;
      end
      OP_FINISH: begin
        first_v      = 1'b1;
        first.kind   = CMD_FINISH;
        pend_v_d     = 1'b0;
      end
      OP_ENC, OP_DEC: begin
        if (pend_v_q) begin
          first_v = 1'b1;
          if (x == pend_l_q) begin
            // doubled letter: split with filler, x stays pending unless the message ends
            first = mk_pair(pend_l_q, fill, dec, 1'b0);
            if (message_end_i) begin
              second_v = 1'b1;
              pend_v_d = 1'b0;
            end
          end else begin
            first    = mk_pair(pend_l_q, x, dec, message_end_i);
            pend_v_d = 1'b0;
          end
        end else begin
          pend_l_d = x;
          pend_v_d = 1'b1;
          if (message_end_i) begin
            first_v  = 1'b1;
            first    = mk_pair(x, fill, dec, 1'b1);
            pend_v_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      pend_v_d = pend_v_q;
      pend_l_d = pend_l_q;
    end

    if (spare_v_q) begin
      cq_push_o = ~cq_full_i;
      cq_cmd_o  = spare_q;
      spare_v_d = cq_full_i;
      spare_d   = spare_q;
    end else begin
      cq_push_o = accept & first_v;
      cq_cmd_o  = first;
      spare_v_d = accept & second_v;
      spare_d   = second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filler_q  <= FILLER_RESET;
      pend_v_q  <= 1'b0;
      pend_l_q  <= '0;
      spare_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) filler_q <= cfg_data_i;
      pend_v_q  <= pend_v_d;
      pend_l_q  <= pend_l_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spare_q <= spare_d;
  end

endmodule

`default_nettype wire

/* sv/pf_cmd_fifo.sv */
`default_nettype none

module pf_cmd_fifo import pf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_q, rd_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

endmodule

`default_nettype wire

/* sv/pf_back.sv */
`default_nettype none

module pf_back import pf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cq_cmd_i,
  input  logic       cq_empty_i,
  output logic       cq_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] out_letter_o,
  output logic       out_last_o
);

  back_st_e st_q, st_d;

  logic [4:0] sq_mem  [SQUARE_CELLS];
  logic [4:0] pos_mem [ALPHABET];

  logic [ALPHABET-1:0] placed_q;
  logic [4:0]          fill_q;
  logic [4:0]          walk_q;
  logic [4:0]          pa_q, pb_q, sx_q, sy_q;
  logic                dec_q, last_q;

  res_t               res_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0] rwr_q, rrd_q;
  logic [RESQ_AW:0]   rcnt_q;
  logic               res_full, res_push, res_pop;
  res_t               res_d;

  logic       place_req, place_en, clr, walk_start, pos_rd, sq_rd;
  logic [4:0] place_ltr;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] ax, ay;

  assign res_full     = (rcnt_q == (RESQ_AW+1)'(RESQ_DEPTH));
  assign empty        = (rcnt_q == '0);
  assign res_pop      = pop & ~empty;
  assign out_letter_o = res_q[rrd_q].letter;
  assign out_last_o   = res_q[rrd_q].last;

  always_comb begin
    st_d         = st_q;
    cq_pop_o     = 1'b0;
    place_req    = 1'b0;
    place_ltr    = cq_cmd_i.a;
    clr          = 1'b0;
    walk_start   = 1'b0;
    pos_rd       = 1'b0;
    sq_rd        = 1'b0;
    res_push     = 1'b0;
    res_d.letter = sx_q;
    res_d.last   = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!cq_empty_i) begin
          cq_pop_o = 1'b1;
          case (cq_cmd_i.kind)
            CMD_START:  clr = 1'b1;
            CMD_PLACE:  place_req = 1'b1;
            CMD_FINISH: begin
              walk_start = 1'b1;
              st_d       = ST_FILL;
            end
            CMD_PAIR: begin
              pos_rd = 1'b1;
              st_d   = ST_LOOK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        place_ltr = walk_q;
        place_req = (walk_q != LETTER_J);
        if (walk_q == LETTER_Z) st_d = ST_IDLE;
      end
      ST_LOOK: begin
        sq_rd = 1'b1;
        st_d  = ST_EMIT0;
      end
      ST_EMIT0: begin
        if (!res_full) begin
          res_push = 1'b1;
          st_d     = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        res_d.letter = sy_q;
        res_d.last   = last_q;
        if (!res_full) begin
          res_push = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    place_en = place_req & ~placed_q[place_ltr] & (fill_q < SQUARE_CELLS);
  end

  // cell lookup for the pair
  always_comb begin
    ra = pos_row(pa_q);
    ca = pos_col(pa_q);
    rb = pos_row(pb_q);
    cb = pos_col(pb_q);
    if (ra == rb) begin
      ax = cell_addr(ra, step5(ca, dec_q));
      ay = cell_addr(rb, step5(cb, dec_q));
    end else if (ca == cb) begin
      ax = cell_addr(step5(ra, dec_q), ca);
      ay = cell_addr(step5(rb, dec_q), cb);
    end else begin
      ax = cell_addr(ra, cb);
      ay = cell_addr(rb, ca);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      placed_q <= '0;
      fill_q   <= '0;
      walk_q   <= '0;
      rwr_q    <= '0;
      rrd_q    <= '0;
      rcnt_q   <= '0;
    end else begin
      st_q <= st_d;
      if (clr) begin
        placed_q <= '0;
        fill_q   <= '0;
      end else if (place_en) begin
        placed_q[place_ltr] <= 1'b1;
        fill_q              <= fill_q + 5'd1;
      end
      if (walk_start)          walk_q <= '0;
      else if (st_q == ST_FILL) walk_q <= walk_q + 5'd1;
      if (res_push) rwr_q <= rwr_q + 1'b1;
      if (res_pop)  rrd_q <= rrd_q + 1'b1;
      if (res_push && !res_pop)      rcnt_q <= rcnt_q + 1'b1;
      else if (!res_push && res_pop) rcnt_q <= rcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_q]     <= place_ltr;
      pos_mem[place_ltr] <= fill_q;
    end
    if (pos_rd) begin
      pa_q   <= pos_mem[cq_cmd_i.a];
      pb_q   <= pos_mem[cq_cmd_i.b];
      dec_q  <= cq_cmd_i.dec;
      last_q <= cq_cmd_i.last;
    end
    if (sq_rd) begin
      sx_q <= sq_mem[ax];
      sy_q <= sq_mem[ay];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) res_q[rwr_q] <= res_d;
  end

endmodule

`default_nettype wire

/* sv/playfair_digraph_cipher.sv */
`default_nettype none
// channel   dir  handshake               payload
// item      in   push / full             operation_i, letter_i, message_end_i
// result    out  empty / pop             out_letter_o, out_last_o
// config    in   cfg_valid_i/cfg_ready_o cfg_data_i (filler letter)
//
// A cipher pair goes through position read, square read and two result beats; the
// beats wait while the result queue is full, and no new command is popped meanwhile.
// Key letters and start are handled on pop; finish pops, then walks the 26 letters.
// An item that yields two pairs holds full high until its second pair is queued.
// Reset is asynchronous, active low; no clearing pass, the block is ready at once.
// A 4-deep command queue lets input run ahead while results wait to be popped.

module playfair_digraph_cipher import pf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation_i,
  input  logic [4:0] letter_i,
  input  logic       message_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] out_letter_o,
  output logic       out_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wr, cq_rd;

  pf_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .operation_i,
    .letter_i,
    .message_end_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .cq_push_o (cq_push),
    .cq_cmd_o  (cq_wr),
    .cq_full_i (cq_full)
  );

  pf_cmd_fifo u_cmdq (
    .clk_i,
    .rst_ni,
    .push_i  (cq_push),
    .cmd_i   (cq_wr),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .cmd_o   (cq_rd),
    .empty_o (cq_empty)
  );

  pf_back u_back (
    .clk_i,
    .rst_ni,
    .cq_cmd_i   (cq_rd),
    .cq_empty_i (cq_empty),
    .cq_pop_o   (cq_pop),
    .empty,
    .pop,
    .out_letter_o,
    .out_last_o
  );

endmodule

`default_nettype wire

/* sv/pf_checker.sv */
`default_nettype none

module pf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [4:0] out_letter_o,
  input logic       out_last_o
);

  // no result held while in reset
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // input side open during reset
  a_rst_full: assert property (@(posedge clk_i) !rst_ni |-> !full)
    else $error("full during reset");

  // no result right after reset release
  a_post_rst: assert property (@(posedge clk_i) $past(!rst_ni) |-> empty)
    else $error("result right after reset");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !empty && !pop |=> !empty && $stable(out_letter_o) && $stable(out_last_o))
    else $error("stalled result changed");

endmodule

bind playfair_digraph_cipher pf_checker u_pf_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench import pf_pkg::*;;

  localparam int unsigned DRAIN_CYCLES = 150;   // four queued finish commands plus results
  localparam int unsigned STALL_LIMIT  = 2000;

  // Tracks the 5x5 square and the pairing of cipher letters; holds the result
  // beats still owed by the block.
  class cipher_scoreboard;
    logic [4:0]  filler;
    logic [4:0]  square[25];
    logic [5:0]  where[26];
    bit          placed[26];
    int unsigned filled;
    bit          held_valid;
    logic [4:0]  held;
    res_t        owed_q[$];

    function new();
      filler     = FILLER_RESET;
      square     = '{default: '0};
      where      = '{default: '0};
      placed     = '{default: 1'b0};
      filled     = 0;
      held_valid = 1'b0;
      held       = '0;
    endfunction

    function void set_filler(logic [4:0] v);
      filler = v;
    endfunction

    // saturate to Z, J folds into I
    function logic [4:0] fold(logic [4:0] v);
      if (v > LETTER_Z) return LETTER_Z;
      if (v == LETTER_J) return LETTER_I;
      return v;
    endfunction

    function void place(logic [4:0] x);
      if (placed[x] || filled >= 25) return;
      square[filled] = x;
      where[x]       = 6'(filled);
      placed[x]      = 1'b1;
      filled++;
    endfunction

    function void cipher_pair(logic [4:0] a, logic [4:0] b, bit dec, bit fin);
      int unsigned pa, pb, ra, ca, rb, cb, d;
      res_t r0, r1;
      pa = where[a] % 25;
      pb = where[b] % 25;
      ra = pa / 5;
      ca = pa % 5;
      rb = pb / 5;
      cb = pb % 5;
      d  = dec ? 4 : 1;
      if (ra == rb) begin
        r0.letter = square[ra * 5 + (ca + d) % 5];
        r1.letter = square[rb * 5 + (cb + d) % 5];
      end else if (ca == cb) begin
        r0.letter = square[((ra + d) % 5) * 5 + ca];
        r1.letter = square[((rb + d) % 5) * 5 + cb];
      end else begin
        r0.letter = square[ra * 5 + cb];
        r1.letter = square[rb * 5 + ca];
      end
      r0.last = 1'b0;
      r1.last = fin;
      owed_q.insert(owed_q.size(), r0);
      owed_q.insert(owed_q.size(), r1);
    endfunction

    function void note_item(logic [2:0] op, logic [4:0] raw, bit fin);
      logic [4:0] x, pad;
      bit dec;
      x   = fold(raw);
      pad = fold(filler);
      dec = (op == OP_DEC);
      case (op)
        OP_START: begin
          placed     = '{default: 1'b0};
          filled     = 0;
          held_valid = 1'b0;
        end
        OP_KEY: place(x);
        OP_FINISH: begin
          for (int i = 0; i < ALPHABET; i++)
            if (5'(i) != LETTER_J) place(5'(i));
          held_valid = 1'b0;
        end
        OP_ENC, OP_DEC: begin
          if (held_valid && x != held) begin
            cipher_pair(held, x, dec, fin);
            held_valid = 1'b0;
          end else begin
            // no letter waiting, or a doubled letter split with the filler: the new one waits
            if (held_valid) cipher_pair(held, pad, dec, 1'b0);
            held       = x;
            held_valid = 1'b1;
            if (fin) begin
              cipher_pair(held, pad, dec, 1'b1);
              held_valid = 1'b0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function string check(logic [4:0] got_letter, logic got_last);
      res_t want;
      if (owed_q.size() == 0)
        return $sformatf("result beat letter %0d last %0b with nothing owed",
                         got_letter, got_last);
      want = owed_q.pop_front();
      if (want.letter !== got_letter || want.last !== got_last)
        return $sformatf("result beat letter %0d last %0b, want letter %0d last %0b",
                         got_letter, got_last, want.letter, want.last);
      return "";
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [2:0] operation_i;
  logic [4:0] letter_i;
  logic       message_end_i;
  logic       empty;
  logic       pop;
  logic [4:0] out_letter_o;
  logic       out_last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i;

  cipher_scoreboard sb;
  int unsigned      mismatches = 0;
  int unsigned      stalled = 0;
  bit               calm;

  playfair_digraph_cipher uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .operation_i  (operation_i),
    .letter_i     (letter_i),
    .message_end_i(message_end_i),
    .empty        (empty),
    .pop          (pop),
    .out_letter_o (out_letter_o),
    .out_last_o   (out_last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni) begin
      stalled++;
      if (pop && !empty) begin
        msg = sb.check(out_letter_o, out_last_o);
        if (msg != "") report(msg);
        stalled = 0;
      end
      if (push && !full) begin
        sb.note_item(operation_i, letter_i, message_end_i);
        stalled = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_filler(cfg_data_i);
        stalled = 0;
      end
    end
  end

  always @(posedge clk_i) pop <= calm || ($urandom_range(99) >= 30);

  // push stays high from one beat to the next; only gaps and settle lower it
  task automatic drive_item(logic [2:0] op, logic [4:0] letter, bit fin);
    if (!calm)
      while ($urandom_range(99) < 30) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    push          <= 1'b1;
    operation_i   <= op;
    letter_i      <= letter;
    message_end_i <= fin;
    do @(posedge clk_i); while (full);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_filler(logic [4:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n_cipher);
    int unsigned done, roll, nkeys;
    logic [4:0]  prev, pick;
    bit          dec_dir;
    done    = 0;
    prev    = '0;
    dec_dir = 1'b0;
    while (done < n_cipher) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        // new key: sometimes more letters than the square holds
        drive_item(OP_START, 5'($urandom), 1'($urandom));
        nkeys = ($urandom_range(9) == 0) ? $urandom_range(40, 26) : $urandom_range(8, 1);
        repeat (nkeys) drive_item(OP_KEY, 5'($urandom), 1'($urandom));
        drive_item(OP_FINISH, 5'($urandom), 1'($urandom));
      end else if (roll < 7) begin
        case ($urandom_range(2))
          0:       drive_item(3'($urandom_range(7, 5)), 5'($urandom), 1'($urandom));
          1:       drive_item(OP_START, 5'($urandom), 1'($urandom));
          default: drive_item(OP_FINISH, 5'($urandom), 1'($urandom));
        endcase
      end else begin
        if ($urandom_range(9) == 0) dec_dir = ~dec_dir;
        if ($urandom_range(4) == 0)      pick = prev;
        else if ($urandom_range(9) == 0) pick = 5'($urandom_range(31, 26));
        else                             pick = 5'($urandom_range(25));
        drive_item(dec_dir ? OP_DEC : OP_ENC, pick, $urandom_range(5) == 0);
        prev = pick;
        done++;
      end
    end
  endtask

  initial begin
    while (stalled < STALL_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [4:0] fillers[5];
    sb            = new();
    calm          = 1'b0;
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    operation_i   <= '0;
    letter_i      <= '0;
    message_end_i <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // key with a repeat, J, an out-of-range code and a stray message end
    drive_item(OP_START, 5'd0, 1'b0);
    drive_item(OP_KEY, 5'd15, 1'b0);
    drive_item(OP_KEY, 5'd11, 1'b0);
    drive_item(OP_KEY, 5'd0, 1'b0);
    drive_item(OP_KEY, 5'd24, 1'b1);
    drive_item(OP_KEY, 5'd31, 1'b0);
    drive_item(OP_KEY, 5'd9, 1'b0);
    drive_item(OP_KEY, 5'd0, 1'b0);
    drive_item(OP_FINISH, 5'd31, 1'b1);
    drive_item(OP_ENC, 5'd15, 1'b0);
    drive_item(OP_ENC, 5'd11, 1'b0);
    drive_item(OP_ENC, 5'd7, 1'b0);
    drive_item(OP_ENC, 5'd7, 1'b0);
    drive_item(OP_ENC, 5'd31, 1'b1);
    drive_item(OP_ENC, 5'd23, 1'b1);   // pad equals its partner
    drive_item(OP_ENC, 5'd0, 1'b0);
    drive_item(OP_DEC, 5'd4, 1'b1);    // pair finished in the other direction
    drive_item(3'd5, 5'd3, 1'b1);
    drive_item(3'd7, 5'd31, 1'b1);
    drive_item(OP_ENC, 5'd3, 1'b0);
    drive_item(OP_FINISH, 5'd0, 1'b0); // drops the waiting letter
    drive_item(OP_KEY, 5'd2, 1'b0);    // square already full
    drive_item(OP_DEC, 5'd26, 1'b0);
    drive_item(OP_DEC, 5'd30, 1'b1);   // split and pad: four beats

    fillers = '{5'd0, 5'd25, 5'd9, 5'd31, 5'($urandom)};
    foreach (fillers[i]) begin
      settle();
      write_filler(fillers[i]);
      calm = (i == 2);
      run_phase(55);
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/pf_pkg.sv
sv/pf_front.sv
sv/pf_cmd_fifo.sv
sv/pf_back.sv
sv/playfair_digraph_cipher.sv
sv/pf_checker.sv
dv/testbench.sv
